// ----- src/cvp_pkg.sv -----
// ----------------------------------------------------------------------------
// Column value profiler package
// Shared constants and a helper function for binary64 compare and checks.
// ----------------------------------------------------------------------------
package cvp_pkg;

    localparam logic [63:0] BITS_DBL_MAX     = 64'h7FEF_FFFF_FFFF_FFFF;
    localparam logic [63:0] BITS_NEG_DBL_MAX = 64'hFFEF_FFFF_FFFF_FFFF;
    localparam int          CNT_W            = 6;

    typedef struct packed {
        logic       is_nan;
        logic       lt;
        logic       gt;
        logic       eq;
    } t_cmp;

    // Numeric comparison of a against b, both binary64 bit patterns.
    function automatic t_cmp fp_cmp(input logic [63:0] a, input logic [63:0] b);
        t_cmp r;
        logic a_nan;
        logic b_nan;
        logic a_zero;
        logic b_zero;
        logic mag_lt;
        logic mag_eq;
        a_nan  = (a[62:52] == 11'h7FF) && (a[51:0] != '0);
        b_nan  = (b[62:52] == 11'h7FF) && (b[51:0] != '0);
        a_zero = (a[62:0] == '0);
        b_zero = (b[62:0] == '0);
        mag_lt = a[62:0] < b[62:0];
        mag_eq = a[62:0] == b[62:0];
        r.is_nan = a_nan || b_nan;
        if (r.is_nan) begin
            r.lt = 1'b0;
            r.gt = 1'b0;
            r.eq = 1'b0;
        end else if (a_zero && b_zero) begin
            r.lt = 1'b0;
            r.gt = 1'b0;
            r.eq = 1'b1;
        end else if (a[63] != b[63]) begin
            r.lt = a[63];
            r.gt = b[63];
            r.eq = 1'b0;
        end else begin
            r.eq = mag_eq;
            r.lt = a[63] ? (!mag_lt && !mag_eq) : mag_lt;
            r.gt = !r.eq && !r.lt;
        end
        return r;
    endfunction

endpackage

// ----- src/column_value_profiler_unit.sv -----
// ----------------------------------------------------------------------------
// Column value profiler
// Per-column running min, max, binary32 fit flag and distinct value count.
// ----------------------------------------------------------------------------
// One request is taken at a time. Between one acceptance and the next ready
// the distinct table memory is read one entry a cycle through one shared
// comparator, over at most n entries, where n is the column's current
// distinct count; the search stops at the first equal entry. An empty or
// saturated column (count DISTINCT_LIMIT + 1) skips the search. The result
// is held in an output register while the next request is taken; a request
// whose result finds that register still full waits until it drains.
module column_value_profiler_unit #(
    parameter int NUM_COLUMNS    = 16,
    parameter int DISTINCT_LIMIT = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // column[3:0], sample[67:4], zero pad
    input  logic        m_axis_tready,
    output logic        m_axis_tvalid,
    output logic [143:0] m_axis_tdata  // out_column, running_min, running_max,
                                       // distinct_count, fits_single, was_new
);
    import cvp_pkg::*;

    localparam int COL_W = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
    localparam int IDX_W = (DISTINCT_LIMIT > 1) ? $clog2(DISTINCT_LIMIT) : 1;
    localparam int DEPTH = NUM_COLUMNS * DISTINCT_LIMIT;
    localparam int ADR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(DISTINCT_LIMIT + 1);
    localparam logic [CNT_W-1:0] CNT_LIM = CNT_W'(DISTINCT_LIMIT);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_SRCH  = 5'b00100,
        S_WRITE = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state            r_state;
    logic [3:0]        r_col_in;
    logic [COL_W-1:0]  r_col;
    logic [63:0]       r_bits;
    logic [63:0]       r_min [NUM_COLUMNS];
    logic [63:0]       r_max [NUM_COLUMNS];
    logic              r_fit [NUM_COLUMNS];
    logic [CNT_W-1:0]  r_cnt [NUM_COLUMNS];
    logic [63:0]       r_tab [DEPTH];
    logic [63:0]       r_rd;
    logic [CNT_W-1:0]  r_j;
    logic              r_found;
    logic              r_rd_vld;
    logic              r_ovalid;
    logic [143:0]      r_odata;
    logic              r_new;
    logic              w_fit_ok;
    logic [COL_W-1:0]  w_col_map [16];
    logic [COL_W-1:0]  n_col;
    logic [CNT_W-1:0]  w_cnt;
    logic [ADR_W-1:0]  w_rd_adr;
    logic [ADR_W-1:0]  w_wr_adr;
    logic [63:0]       w_opnd;
    t_cmp              w_cmp;
    logic              w_hit;
    logic              w_new;

    cvp_fit_check u_fit (
        .i_clk  (i_clk),
        .i_bits (r_bits),
        .o_ok   (w_fit_ok)
    );

    always_comb begin
        for (int k = 0; k < 16; k++) begin
            w_col_map[k] = COL_W'(k % NUM_COLUMNS);
        end
    end

    always_comb begin
        case (r_state)
            S_READ:  w_opnd = r_min[r_col];
            S_WRITE: w_opnd = r_max[r_col];
            default: w_opnd = r_rd;
        endcase
    end

    assign n_col    = w_col_map[s_axis_tdata[3:0]];
    assign w_cnt    = r_cnt[r_col];
    assign w_rd_adr = ADR_W'(32'(r_col) * DISTINCT_LIMIT + 32'(r_j[IDX_W-1:0]));
    assign w_wr_adr = ADR_W'(32'(r_col) * DISTINCT_LIMIT + 32'(w_cnt[IDX_W-1:0]));
    assign w_cmp    = fp_cmp(r_bits, w_opnd);
    assign w_hit    = r_rd_vld && w_cmp.eq;
    assign w_new    = (w_cnt != CNT_SAT) && !r_found;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    always_ff @(posedge i_clk) begin
        r_rd <= r_tab[w_rd_adr];
        if (r_state == S_WRITE && w_new && w_cnt < CNT_LIM) begin
            r_tab[w_wr_adr] <= r_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_rd_vld <= 1'b0;
            r_found  <= 1'b0;
            r_j      <= '0;
            for (int c = 0; c < NUM_COLUMNS; c++) begin
                r_min[c] <= BITS_DBL_MAX;
                r_max[c] <= BITS_NEG_DBL_MAX;
                r_fit[c] <= 1'b1;
                r_cnt[c] <= '0;
            end
        end else begin
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_col_in <= s_axis_tdata[3:0];
                        r_col    <= n_col;
                        r_bits   <= s_axis_tdata[67:4];
                        r_j      <= '0;
                        r_found  <= 1'b0;
                        r_rd_vld <= 1'b0;
                        r_state  <= S_READ;
                    end
                end
                S_READ: begin
                    if (w_cmp.lt) r_min[r_col] <= r_bits;
                    if (w_cnt == CNT_SAT || w_cnt == '0) begin
                        r_state <= S_WRITE;
                    end else begin
                        r_j      <= r_j + 1'b1;
                        r_rd_vld <= 1'b1;
                        r_state  <= S_SRCH;
                    end
                end
                S_SRCH: begin
                    if (w_hit) begin
                        r_found  <= 1'b1;
                        r_rd_vld <= 1'b0;
                        r_state  <= S_WRITE;
                    end else if (r_j == w_cnt) begin
                        r_rd_vld <= 1'b0;
                        r_state  <= S_WRITE;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_WRITE: begin
                    if (w_cmp.gt) r_max[r_col] <= r_bits;
                    if (!w_fit_ok) r_fit[r_col] <= 1'b0;
                    if (w_new) r_cnt[r_col] <= w_cnt + 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        r_odata  <= {4'd0, r_new, r_fit[r_col], r_cnt[r_col],
                                     r_max[r_col], r_min[r_col], r_col_in};
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE) r_new <= w_new;
    end

endmodule

// ----- src/cvp_fit_check.sv -----
// ----------------------------------------------------------------------------
// Binary32 round-trip check
// Registered test whether a binary64 sample survives a round trip to
// binary32 within an absolute error of 1e-6. The result is valid in the
// cycle after the sample is presented.
// ----------------------------------------------------------------------------
module cvp_fit_check (
    input  logic        i_clk,
    input  logic [63:0] i_bits,
    output logic        o_ok
);
    // Significand of the binary64 nearest to 1e-6, whose value is TOL_MANT * 2^-72.
    localparam logic [52:0] TOL_MANT      = 53'h10_C6F7_A0B5_ED8D;
    localparam logic [62:0] FLT_MAX_MAG   = 63'h47EF_FFFF_E000_0000;
    localparam logic [10:0] EXP_SPECIAL   = 11'h7FF;
    localparam logic [10:0] EXP_SMALL_MAX = 11'd1027;
    localparam logic [10:0] EXP_TOL_BASE  = 11'd1003;

    logic [10:0] w_exp;
    logic [28:0] w_tail;
    logic [28:0] w_err;
    logic [10:0] w_sh;
    logic [52:0] w_lim;
    logic        n_ok;
    logic        r_ok;

    // Rounding to 24 significant bits leaves an error of the nearer of the
    // dropped part and its complement, in units of the binary64 step. Below
    // 2^5 that error is always under the tolerance.
    always_comb begin
        w_exp  = i_bits[62:52];
        w_tail = i_bits[28:0];
        w_err  = w_tail[28] ? (29'd0 - w_tail) : w_tail;
        w_sh   = w_exp - EXP_TOL_BASE;
        w_lim  = TOL_MANT >> w_sh;
        if (w_exp == EXP_SPECIAL) begin
            n_ok = 1'b1;
        end else if (i_bits[62:0] > FLT_MAX_MAG) begin
            n_ok = 1'b0;
        end else if (w_exp <= EXP_SMALL_MAX) begin
            n_ok = 1'b1;
        end else begin
            n_ok = ({24'd0, w_err} <= w_lim);
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok <= n_ok;
    end

    assign o_ok = r_ok;

endmodule

// ----- src/cvp_checker.sv -----
// ----------------------------------------------------------------------------
// Column value profiler port checker
// Concurrent checks on the top level ports, bound to the top level.
// ----------------------------------------------------------------------------
module cvp_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [143:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while busy");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[137:132] <= 6'd63)
        else $error("count out of range");
    a_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[139] |-> m_axis_tdata[137:132] != 6'd0)
        else $error("new value with zero count");
endmodule

bind column_value_profiler_unit cvp_checker u_cvp_checker (.*);

// ----- tb/column_value_profiler_checker.sv -----
// ----------------------------------------------------------------------------
// Column value profiler checker
// Watches both stream channels, predicts each column's statistics for every
// accepted request and compares every result field with the oldest one due.
// ----------------------------------------------------------------------------
module column_value_profiler_checker #(
    parameter int NUM_COLUMNS    = 16,
    parameter int DISTINCT_LIMIT = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_req_valid,
    input  logic         i_req_ready,
    input  logic [71:0]  i_req_data,   // column[3:0], sample[67:4], zero pad
    input  logic         i_res_valid,
    input  logic         i_res_ready,
    input  logic [143:0] i_res_data,   // out_column, running_min, running_max,
                                       // distinct_count, fits_single, was_new
    output int           o_errors,
    output int           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import cvp_pkg::*;

    localparam logic [63:0] BITS_FLT_MAX = 64'h47EF_FFFF_E000_0000;

    typedef struct packed {
        logic [3:0]       column;
        logic [63:0]      run_min;
        logic [63:0]      run_max;
        logic [CNT_W-1:0] count;
        logic             fits;
        logic             fresh;
    } t_stats;

    logic [63:0]      col_min   [NUM_COLUMNS];
    logic [63:0]      col_max   [NUM_COLUMNS];
    logic             col_fits  [NUM_COLUMNS];
    logic [CNT_W-1:0] col_count [NUM_COLUMNS];
    logic [63:0]      seen_vals [NUM_COLUMNS][DISTINCT_LIMIT];
    t_stats           stats_due [$];

    // Rounds to binary32 (nearest even) and back, and checks the error.
    function automatic bit survives_single(input logic [63:0] bits);
        logic [33:0] head;
        logic [28:0] tail;
        logic [63:0] back;
        real         diff;
        if (bits[62:52] == 11'h7FF)
            return 1'b1;
        if ($bitstoreal(bits) > $bitstoreal(BITS_FLT_MAX) ||
            $bitstoreal(bits) < -$bitstoreal(BITS_FLT_MAX))
            return 1'b0;
        if (bits[62:52] < 11'd897)
            return 1'b1;
        head = {bits[62:52], bits[51:29]};
        tail = bits[28:0];
        if (tail > 29'h1000_0000 || (tail == 29'h1000_0000 && head[0]))
            head = head + 34'd1;
        back = {bits[63], head, 29'd0};
        diff = $bitstoreal(back) - $bitstoreal(bits);
        return !(diff >= 0.000001 || diff <= -0.000001);
    endfunction

    function automatic t_stats profile_sample(input logic [3:0] column,
                                              input logic [63:0] bits);
        t_stats r;
        int     c;
        int     n;
        bit     hit;
        real    v;
        c   = column % NUM_COLUMNS;
        v   = $bitstoreal(bits);
        hit = 1'b0;
        if (v > $bitstoreal(col_max[c]))
            col_max[c] = bits;
        if (v < $bitstoreal(col_min[c]))
            col_min[c] = bits;
        if (col_fits[c] && !survives_single(bits))
            col_fits[c] = 1'b0;
        n = col_count[c];
        r.fresh = 1'b0;
        if (n <= DISTINCT_LIMIT) begin
            for (int j = 0; j < n && j < DISTINCT_LIMIT; j++)
                if ($bitstoreal(seen_vals[c][j]) == v)
                    hit = 1'b1;
            if (!hit) begin
                if (n < DISTINCT_LIMIT)
                    seen_vals[c][n] = bits;
                col_count[c] = CNT_W'(n + 1);
                r.fresh = 1'b1;
            end
        end
        r.column  = column;
        r.run_min = col_min[c];
        r.run_max = col_max[c];
        r.count   = col_count[c];
        r.fits    = col_fits[c];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_stats want;
        t_stats got;
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_COLUMNS; c++) begin
                col_min[c]   = BITS_DBL_MAX;
                col_max[c]   = BITS_NEG_DBL_MAX;
                col_fits[c]  = 1'b1;
                col_count[c] = '0;
            end
            stats_due.delete();
            o_errors  <= 0;
            o_pending <= 0;
        end else begin
            if (i_req_valid && i_req_ready)
                stats_due.push_back(profile_sample(i_req_data[3:0], i_req_data[67:4]));
            if (i_res_valid && i_res_ready) begin
                got = {i_res_data[3:0], i_res_data[67:4], i_res_data[131:68],
                       i_res_data[137:132], i_res_data[138], i_res_data[139]};
                if (stats_due.size() == 0) begin
                    $display("%0t: result with none due, actual %h", $time, got);
                    o_errors <= o_errors + 1;
                end else begin
                    want = stats_due.pop_front();
                    if (want.column !== got.column || want.run_min !== got.run_min ||
                        want.run_max !== got.run_max || want.count !== got.count ||
                        want.fits !== got.fits || want.fresh !== got.fresh) begin
                        $display("%0t: column exp %h act %h, min exp %h act %h",
                                 $time, want.column, got.column, want.run_min,
                                 got.run_min);
                        $display("%0t: max exp %h act %h, count exp %0d act %0d",
                                 $time, want.run_max, got.run_max, want.count,
                                 got.count);
                        $display("%0t: fits exp %b act %b, new exp %b act %b",
                                 $time, want.fits, got.fits, want.fresh, got.fresh);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= stats_due.size();
        end
    end

endmodule

// ----- tb/tb_column_value_profiler_unit.sv -----
// ----------------------------------------------------------------------------
// Column value profiler testbench
// Sends directed, then random samples with random gaps and output stalls;
// the checker predicts and compares, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_column_value_profiler_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS     = 750;
    localparam int CALM_TAIL = 100;
    localparam int MAX_CYCLES = 400000;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [71:0]  s_axis_tdata;   // column[3:0], sample[67:4], zero pad
    logic         m_axis_tready;
    logic         m_axis_tvalid;
    logic [143:0] m_axis_tdata;   // out_column, running_min, running_max,
                                  // distinct_count, fits_single, was_new
    int           errors;
    int           pending;
    int           cycles;
    bit           gaps_on;
    int           stall_left;

    column_value_profiler_unit u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tready(m_axis_tready),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tdata (m_axis_tdata)
    );

    column_value_profiler_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(s_axis_tvalid),
        .i_req_ready(s_axis_tready),
        .i_req_data (s_axis_tdata),
        .i_res_valid(m_axis_tvalid),
        .i_res_ready(m_axis_tready),
        .i_res_data (m_axis_tdata),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (gaps_on && stall_left == 0 && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 15);
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_sample(input logic [3:0] column, input logic [63:0] bits);
        int gap;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, bits, column};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    function automatic logic [63:0] pick_sample(input int kind);
        case (kind)
            0, 1, 2, 3: return $realtobits(real'($urandom_range(0, 7)));
            4, 5:       return $realtobits((real'($urandom_range(0, 2000)) - 1000.0) / 16.0);
            9: begin
                case ($urandom_range(0, 5))
                    0: return 64'h7FF0_0000_0000_0000;
                    1: return 64'hFFF0_0000_0000_0000;
                    2: return 64'h7FF8_0000_0000_0001;
                    3: return 64'h8000_0000_0000_0000;
                    4: return $realtobits(0.1);
                    default: return 64'h4800_0000_0000_0000;
                endcase
            end
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin
        logic [63:0] directed [18];
        int          kind;
        logic [3:0]  column;
        directed = '{64'h0000_0000_0000_0000, 64'h8000_0000_0000_0000,
                     64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000,
                     64'h7FF8_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
                     64'h7FEF_FFFF_FFFF_FFFF, 64'hFFEF_FFFF_FFFF_FFFF,
                     64'h3FF0_0000_0000_0000, 64'h47EF_FFFF_E000_0000,
                     64'h47EF_FFFF_F000_0000, 64'h3FB9_9999_9999_999A,
                     64'h0000_0000_0000_0001, 64'h3FF8_0000_0000_0000,
                     64'hBFF0_0000_0000_0000, 64'h3FF0_0000_0000_0000,
                     64'h7FF8_0000_0000_0000, 64'h8000_0000_0000_0000};
        cycles        = 0;
        gaps_on       = 1'b0;
        stall_left    = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < 18; i++)
            send_sample((i < 9) ? 4'd0 : 4'd15, directed[i]);
        for (int i = 0; i < 34; i++)
            send_sample(4'd7, $realtobits(real'(i)));
        send_sample(4'd7, $realtobits(2.0));

        gaps_on = 1'b1;
        for (int i = 0; i < ITEMS; i++) begin
            if (i == ITEMS - CALM_TAIL)
                gaps_on = 1'b0;
            kind   = $urandom_range(0, 9);
            column = 4'((kind >= 6 && kind <= 8) ? $urandom_range(0, 3)
                                                  : $urandom_range(0, 15));
            send_sample(column, pick_sample(kind));
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0)
            @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
